/* src/asbc_pkg.sv */
// shared types, constants and digit helpers for the address setup blink controller
package asbc_pkg;

  localparam int unsigned ADDR_W  = 6;
  localparam int unsigned HOLD_W  = 5;
  localparam int unsigned BLINK_W = 5;
  localparam int unsigned DIGIT_W = 4;

  localparam logic [HOLD_W-1:0]  HOLD_TICKS  = 5'd31;
  localparam logic [BLINK_W-1:0] BLINK_TICKS = 5'd20;
  localparam logic [7:0]         ADDR_MAX    = 8'd63;
  localparam logic [7:0]         LED_FULL    = 8'hFF;
  localparam logic [7:0]         LED_OFF     = 8'h00;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_PRESS   = 2'd1,
    OP_RELEASE = 2'd2,
    OP_LOAD    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PH_ONE_OFF = 3'd0,
    PH_ONE_ON  = 3'd1,
    PH_TWO_OFF = 3'd2,
    PH_TWO_ON  = 3'd3,
    PH_BRK_ON  = 3'd4,
    PH_BRK_OFF = 3'd5
  } phase_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  device_number;
    logic               programming_active;
    logic [HOLD_W-1:0]  hold_counter;
    logic               hold_counting;
    logic               hold_expired;
    logic [BLINK_W-1:0] blink_tick_counter;
    phase_t             blink_phase;
    logic [DIGIT_W-1:0] current_digit;
    logic [DIGIT_W-1:0] digit_flashes;
    logic [7:0]         channel_base;
  } st_t;

  localparam st_t ST_RESET = '{
    device_number:      '0,
    programming_active: 1'b0,
    hold_counter:       '0,
    hold_counting:      1'b0,
    hold_expired:       1'b0,
    blink_tick_counter: '0,
    blink_phase:        PH_BRK_ON,
    current_digit:      '0,
    digit_flashes:      '0,
    channel_base:       8'd1
  };

  typedef struct packed {
    logic [7:0]        led_red;
    logic [7:0]        led_green;
    logic [7:0]        led_blue;
    logic              color_update;
    logic [7:0]        start_channel;
    logic              save_request;
    logic [ADDR_W-1:0] save_value;
    logic              programming;
  } res_t;

  // tens digit by reciprocal multiply, exact for 0..63
  function automatic logic [DIGIT_W-1:0] tens_of(input logic [ADDR_W-1:0] dn);
    logic [13:0] p;
    p = 14'(dn) * 14'd205;
    return DIGIT_W'(p[13:11]);
  endfunction

  function automatic logic [DIGIT_W-1:0] units_of(input logic [ADDR_W-1:0] dn);
    logic [ADDR_W-1:0] t10;
    t10 = ADDR_W'(tens_of(dn)) * ADDR_W'(10);
    return DIGIT_W'(dn - t10);
  endfunction

  // start channel is four times the address plus one
  function automatic logic [7:0] chan_of(input logic [ADDR_W-1:0] dn);
    return {dn, 2'b01};
  endfunction

endpackage

/* src/asbc_step.sv */
// next-state and result logic for one event request
module asbc_step (
  input  asbc_pkg::op_t              op,
  input  logic [7:0]                 stored_address,
  input  asbc_pkg::st_t              st,
  output asbc_pkg::st_t              st_nxt,
  output asbc_pkg::res_t             res
);

  logic [asbc_pkg::DIGIT_W-1:0] tens;
  logic [asbc_pkg::DIGIT_W-1:0] units;
  logic [asbc_pkg::ADDR_W-1:0]  load_dn;

  assign tens    = asbc_pkg::tens_of(st.device_number);
  assign units   = asbc_pkg::units_of(st.device_number);
  assign load_dn = (stored_address > asbc_pkg::ADDR_MAX) ? '0
                                                         : stored_address[5:0];

  always_comb begin
    st_nxt = st;
    res    = '0;
    unique case (op)
      asbc_pkg::OP_LOAD: begin
        st_nxt.device_number = load_dn;
        st_nxt.channel_base  = asbc_pkg::chan_of(load_dn);
      end
      asbc_pkg::OP_PRESS: begin
        st_nxt.hold_counter  = '0;
        st_nxt.hold_expired  = 1'b0;
        st_nxt.hold_counting = 1'b1;
      end
      asbc_pkg::OP_RELEASE: begin
        if (!st.hold_expired && st.programming_active) begin
          st_nxt.device_number      = st.device_number + 1'b1;
          st_nxt.blink_phase        = asbc_pkg::PH_BRK_OFF;
          st_nxt.blink_tick_counter = '0;
        end
        st_nxt.hold_counting = 1'b0;
        st_nxt.hold_expired  = 1'b0;
      end
      default: begin
        // tick: hold tracking first, then the blink interval
        if (st.hold_counting) begin
          st_nxt.hold_counter = st.hold_counter + 1'b1;
          if (st_nxt.hold_counter == asbc_pkg::HOLD_TICKS) begin
            st_nxt.hold_expired  = 1'b1;
            st_nxt.hold_counting = 1'b0;
            if (st.programming_active) begin
              st_nxt.programming_active = 1'b0;
              res.save_request          = 1'b1;
              res.save_value            = st.device_number;
              st_nxt.channel_base       = asbc_pkg::chan_of(st.device_number);
            end else begin
              st_nxt.programming_active = 1'b1;
              res.color_update          = 1'b1;
              st_nxt.blink_phase        = asbc_pkg::PH_BRK_OFF;
              st_nxt.blink_tick_counter = '0;
            end
          end
        end
        if (st_nxt.programming_active) begin
          st_nxt.blink_tick_counter = st_nxt.blink_tick_counter + 1'b1;
          if (st_nxt.blink_tick_counter == asbc_pkg::BLINK_TICKS) begin
            st_nxt.blink_tick_counter = '0;
            unique case (st_nxt.blink_phase)
              asbc_pkg::PH_BRK_OFF: begin
                res.led_red       = asbc_pkg::LED_OFF;
                res.led_green     = asbc_pkg::LED_OFF;
                res.led_blue      = asbc_pkg::LED_FULL;
                res.color_update  = 1'b1;
                st_nxt.blink_phase = asbc_pkg::PH_BRK_ON;
              end
              asbc_pkg::PH_BRK_ON: begin
                res.color_update     = 1'b1;
                st_nxt.digit_flashes = '0;
                if (units == '0) begin
                  st_nxt.current_digit = tens;
                  st_nxt.blink_phase   = (tens == '0) ? asbc_pkg::PH_BRK_OFF
                                                      : asbc_pkg::PH_TWO_OFF;
                end else begin
                  st_nxt.current_digit = units;
                  st_nxt.blink_phase   = asbc_pkg::PH_ONE_OFF;
                end
              end
              asbc_pkg::PH_ONE_OFF: begin
                res.led_red        = asbc_pkg::LED_FULL;
                res.color_update   = 1'b1;
                st_nxt.blink_phase = asbc_pkg::PH_ONE_ON;
              end
              asbc_pkg::PH_ONE_ON: begin
                res.color_update     = 1'b1;
                st_nxt.digit_flashes = st_nxt.digit_flashes + 1'b1;
                if (st_nxt.digit_flashes == st_nxt.current_digit) begin
                  st_nxt.current_digit = tens;
                  st_nxt.digit_flashes = '0;
                  st_nxt.blink_phase   = (tens == '0) ? asbc_pkg::PH_BRK_OFF
                                                      : asbc_pkg::PH_TWO_OFF;
                end else begin
                  st_nxt.blink_phase = asbc_pkg::PH_ONE_OFF;
                end
              end
              asbc_pkg::PH_TWO_OFF: begin
                res.led_green      = asbc_pkg::LED_FULL;
                res.color_update   = 1'b1;
                st_nxt.blink_phase = asbc_pkg::PH_TWO_ON;
              end
              asbc_pkg::PH_TWO_ON: begin
                res.color_update     = 1'b1;
                st_nxt.digit_flashes = st_nxt.digit_flashes + 1'b1;
                st_nxt.blink_phase   =
                  (st_nxt.digit_flashes == st_nxt.current_digit) ?
                  asbc_pkg::PH_BRK_OFF : asbc_pkg::PH_TWO_OFF;
              end
              default: begin
              end
            endcase
          end
        end
      end
    endcase
    res.start_channel = st_nxt.channel_base;
    res.programming   = st_nxt.programming_active;
  end

endmodule

/* src/address_setup_blink_controller_top.sv */
// top level of the address setup blink controller: request registers and state
//
// usage
//   input channel: one event request per accepted item (in_valid high, in_stall
//   low at a rising clk edge): tick, button press, button release or load of
//   the saved address byte on in_stored_address
//   result channel: exactly one result request per event, in order, carrying
//   the led color (meaningful with out_color_update), the start channel, a
//   save request with its value, and the programming mode flag
//   path: an accepted event waits in the event register, passes through the
//   combinational update and is presented on the result ports from the result
//   register
//   throughput: one event per cycle while out_stall is low, set by the single
//   event register feeding the combinational update into the result register
//   stall: out_stall holds the result register; the event register still
//   takes one more request, and in_stall rises only when both are full
//   reset: rst_n low at an edge clears both valid flags and returns the state
//   to address 0, start channel 1, normal mode, blink sequencer at break on
module address_setup_blink_controller_top (
  input  logic       clk,
  input  logic       rst_n,
  // event requests
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_stored_address,
  // result requests
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_led_red,
  output logic [7:0] out_led_green,
  output logic [7:0] out_led_blue,
  output logic       out_color_update,
  output logic [7:0] out_start_channel,
  output logic       out_save_request,
  output logic [5:0] out_save_value,
  output logic       out_programming
);

  // event register
  logic           in_valid_r;
  asbc_pkg::op_t  op_r;
  logic [7:0]     addr_r;

  // controller state and result register
  asbc_pkg::st_t  st_r;
  asbc_pkg::st_t  st_nxt;
  asbc_pkg::res_t res_nxt;
  asbc_pkg::res_t res_r;
  logic           out_valid_r;

  // result register is free when empty or being drained this cycle
  logic           adv;
  logic           take;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !adv;
  assign take     = in_valid_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_r   <= asbc_pkg::op_t'(in_operation);
      addr_r <= in_stored_address;
    end
  end

  asbc_step u_step (
    .op             (op_r),
    .stored_address (addr_r),
    .st             (st_r),
    .st_nxt         (st_nxt),
    .res            (res_nxt)
  );

  // state moves only when an event passes into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= asbc_pkg::ST_RESET;
    end else if (take) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_led_red       = res_r.led_red;
  assign out_led_green     = res_r.led_green;
  assign out_led_blue      = res_r.led_blue;
  assign out_color_update  = res_r.color_update;
  assign out_start_channel = res_r.start_channel;
  assign out_save_request  = res_r.save_request;
  assign out_save_value    = res_r.save_value;
  assign out_programming   = res_r.programming;

  // a save only happens when the mode is left
  a_save_leaves_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_save_request |-> !out_programming)
    else $error("save request while still programming");

  // colors are only set while programming
  a_color_in_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_color_update |-> out_programming)
    else $error("color update outside programming mode");

  // saved address matches the start channel set with it
  a_save_matches_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_save_request |-> out_save_value == out_start_channel[7:2])
    else $error("save value and start channel disagree");

  // start channel is always four times an address plus one
  a_chan_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_start_channel[1:0] == 2'b01)
    else $error("malformed start channel");

  // a request taken into the result register leaves it valid next cycle
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_valid_r)
    else $error("accepted event lost before the result register");

endmodule
